// ----- hdl/tdps_pkg.sv -----
package tdps_pkg;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned SLOT_W = $clog2(SLOTS);

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [2:0] POL_FCFS = 3'd0;
  localparam logic [2:0] POL_RR = 3'd1;
  localparam logic [2:0] POL_HRRN = 3'd2;
  localparam logic [2:0] POL_SJF = 3'd3;
  localparam logic [2:0] POL_SRT = 3'd4;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  localparam logic [7:0] QUANTUM_RESET = 8'd5;

  typedef struct packed {
    logic        valid;
    logic [7:0]  job_id;
    logic [9:0]  burst;
    logic [9:0]  remaining;
    logic [15:0] wait_cnt;
    logic [15:0] order;
  } slot_rec_t;

endpackage

// ----- hdl/tick_driven_process_scheduler_top.sv -----
// A request is taken when start_i is high and busy_o is low. busy_o stays high while the
// request runs: the job table is a ring of slot cells that rotates once per pass, one
// cell per cycle, with one pass to place an arrival and two passes per tick (select,
// then update). The result appears for one cycle with result_strobe_o, and the receiver
// cannot stall it; a new request may be issued in that same cycle.
module tick_driven_process_scheduler_top
  import tdps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        opcode_i,
  input  logic [7:0]  job_id_i,
  input  logic [9:0]  burst_length_i,
  output logic        result_strobe_o,
  output logic        arrival_accepted_o,
  output logic        running_valid_o,
  output logic [7:0]  running_id_o,
  output logic        done_valid_o,
  output logic [7:0]  done_id_o,
  output logic [15:0] done_wait_o,
  output logic [31:0] done_time_o
);

  slot_rec_t ring [SLOTS];
  slot_rec_t tail;
  logic      shift;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      tdps_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(shift),
        .rec_i  (tail),
        .rec_o  (ring[i])
      );
    end else begin : g_mid
      tdps_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(shift),
        .rec_i  (ring[i+1]),
        .rec_o  (ring[i])
      );
    end
  end

  tdps_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .opcode_i          (opcode_i),
    .job_id_i          (job_id_i),
    .burst_length_i    (burst_length_i),
    .head_i            (ring[0]),
    .shift_o           (shift),
    .tail_o            (tail),
    .result_strobe_o   (result_strobe_o),
    .arrival_accepted_o(arrival_accepted_o),
    .running_valid_o   (running_valid_o),
    .running_id_o      (running_id_o),
    .done_valid_o      (done_valid_o),
    .done_id_o         (done_id_o),
    .done_wait_o       (done_wait_o),
    .done_time_o       (done_time_o)
  );

endmodule

// ----- hdl/tdps_cell.sv -----
module tdps_cell
  import tdps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      shift_i,
  input  slot_rec_t rec_i,
  output slot_rec_t rec_o
);

  logic      valid_q;
  slot_rec_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= rec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= rec_i;
    end
  end

  always_comb begin
    rec_o = data_q;
    rec_o.valid = valid_q;
  end

endmodule

// ----- hdl/tdps_ctrl.sv -----
module tdps_ctrl
  import tdps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        opcode_i,
  input  logic [7:0]  job_id_i,
  input  logic [9:0]  burst_length_i,
  input  slot_rec_t   head_i,
  output logic        shift_o,
  output slot_rec_t   tail_o,
  output logic        result_strobe_o,
  output logic        arrival_accepted_o,
  output logic        running_valid_o,
  output logic [7:0]  running_id_o,
  output logic        done_valid_o,
  output logic [7:0]  done_id_o,
  output logic [15:0] done_wait_o,
  output logic [31:0] done_time_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ARR = 2'd1;
  localparam logic [1:0] ST_SEL = 2'd2;
  localparam logic [1:0] ST_UPD = 2'd3;

  logic [1:0]        state_q;
  logic [SLOT_W-1:0] step_q;
  logic [2:0]        policy_q;
  logic [7:0]        quantum_q;
  logic [15:0]       counter_q;
  logic [SLOT_W-1:0] cur_q;
  logic              cbusy_q;
  logic [7:0]        qu_q;
  logic [31:0]       elapsed_q;
  logic              preempt_q;
  logic              do_sel_q;
  logic              found_q;
  logic [SLOT_W-1:0] best_q;
  logic [9:0]        best_burst_q;
  logic [9:0]        best_rem_q;
  logic [15:0]       best_wait_q;
  logic [15:0]       best_age_q;
  logic              fin_q;
  logic              rrpre_q;
  logic [7:0]        job_id_q;
  logic [9:0]        burst_q;
  logic              strobe_q;
  logic              acc_q;
  logic              run_v_q;
  logic [7:0]        run_id_q;
  logic              done_v_q;
  logic [7:0]        done_id_q;
  logic [15:0]       done_wait_q;
  logic [31:0]       done_time_q;

  logic              last;
  logic [2:0]        p_eff;
  logic [7:0]        q_eff;
  logic              preempt_now;
  slot_rec_t         h_mod;
  logic [15:0]       age_h;
  logic [26:0]       ratio_a;
  logic [26:0]       ratio_b;
  logic              prefer;
  logic              take;
  logic              found_n;
  logic [SLOT_W-1:0] best_n;
  logic              running;
  logic [9:0]        rem_n;
  logic [7:0]        qu_inc;
  logic              fin_now;
  logic              rrpre_now;
  slot_rec_t         upd;
  slot_rec_t         placed;
  logic              place_now;

  assign last = step_q == SLOT_W'(SLOTS - 1);
  assign p_eff = (policy_q > POL_SRT) ? POL_FCFS : policy_q;
  assign q_eff = (quantum_q == 8'd0) ? 8'd1 : quantum_q;
  assign preempt_now = cbusy_q && (p_eff == POL_RR) && (qu_q >= q_eff);
  assign busy_o = state_q != ST_IDLE;
  assign shift_o = busy_o;

  always_comb begin
    h_mod = head_i;
    if (preempt_q && step_q == cur_q) begin
      h_mod.order = counter_q - 16'd1;
    end
  end

  assign age_h = counter_q - h_mod.order;
  assign ratio_a = (27'(h_mod.wait_cnt) + 27'(h_mod.burst)) * 27'(best_burst_q);
  assign ratio_b = (27'(best_wait_q) + 27'(best_burst_q)) * 27'(h_mod.burst);

  always_comb begin
    prefer = age_h > best_age_q;
    case (p_eff)
      POL_HRRN: if (ratio_a != ratio_b) prefer = ratio_a > ratio_b;
      POL_SJF:  if (h_mod.burst != best_burst_q) prefer = h_mod.burst < best_burst_q;
      POL_SRT:  if (h_mod.remaining != best_rem_q) prefer = h_mod.remaining < best_rem_q;
      default:  prefer = age_h > best_age_q;
    endcase
  end

  assign take = (state_q == ST_SEL) && do_sel_q && h_mod.valid && (!found_q || prefer);
  assign found_n = found_q || take;
  assign best_n = take ? step_q : best_q;

  assign running = cbusy_q && (step_q == cur_q) && head_i.valid;
  assign rem_n = (head_i.remaining != 10'd0) ? head_i.remaining - 10'd1 : 10'd0;
  assign qu_inc = (qu_q == 8'hFF) ? 8'hFF : qu_q + 8'd1;
  assign fin_now = running && (rem_n == 10'd0);
  assign rrpre_now = running && !fin_now && (p_eff == POL_RR) && (qu_inc >= q_eff);

  always_comb begin
    upd = head_i;
    if (running) begin
      upd.remaining = rem_n;
      if (fin_now) begin
        upd.valid = 1'b0;
      end else if (rrpre_now) begin
        upd.order = counter_q;
      end
    end else if (head_i.valid && head_i.wait_cnt != 16'hFFFF) begin
      upd.wait_cnt = head_i.wait_cnt + 16'd1;
    end
  end

  assign place_now = !acc_q && !head_i.valid && (burst_q != 10'd0);

  always_comb begin
    placed.valid = 1'b1;
    placed.job_id = job_id_q;
    placed.burst = burst_q;
    placed.remaining = burst_q;
    placed.wait_cnt = 16'd0;
    placed.order = counter_q;
  end

  always_comb begin
    case (state_q)
      ST_ARR:  tail_o = place_now ? placed : head_i;
      ST_SEL:  tail_o = h_mod;
      ST_UPD:  tail_o = upd;
      default: tail_o = head_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
      policy_q <= POL_FCFS;
      quantum_q <= QUANTUM_RESET;
      counter_q <= 16'd0;
      cur_q <= '0;
      cbusy_q <= 1'b0;
      qu_q <= 8'd0;
      elapsed_q <= 32'd0;
      preempt_q <= 1'b0;
      do_sel_q <= 1'b0;
      found_q <= 1'b0;
      best_q <= '0;
      fin_q <= 1'b0;
      rrpre_q <= 1'b0;
      strobe_q <= 1'b0;
      acc_q <= 1'b0;
      run_v_q <= 1'b0;
      done_v_q <= 1'b0;
    end else begin
      strobe_q <= last && (state_q == ST_ARR || state_q == ST_UPD);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POLICY:  policy_q <= cfg_data_i[2:0];
          CFG_QUANTUM: quantum_q <= cfg_data_i;
          default:     quantum_q <= cfg_data_i;
        endcase
      end
      if (busy_o) begin
        step_q <= step_q + SLOT_W'(1);
      end
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            step_q <= '0;
            acc_q <= 1'b0;
            run_v_q <= 1'b0;
            done_v_q <= 1'b0;
            found_q <= 1'b0;
            fin_q <= 1'b0;
            rrpre_q <= 1'b0;
            if (opcode_i == OP_ARRIVAL) begin
              state_q <= ST_ARR;
            end else begin
              state_q <= ST_SEL;
              elapsed_q <= elapsed_q + 32'd1;
              preempt_q <= preempt_now;
              do_sel_q <= !(cbusy_q && !preempt_now) || (p_eff == POL_SRT);
              if (preempt_now) begin
                counter_q <= counter_q + 16'd1;
                cbusy_q <= 1'b0;
                qu_q <= 8'd0;
              end
            end
          end
        end
        ST_ARR: begin
          if (place_now) begin
            acc_q <= 1'b1;
            counter_q <= counter_q + 16'd1;
          end
          if (last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_SEL: begin
          found_q <= found_n;
          best_q <= best_n;
          if (last) begin
            state_q <= ST_UPD;
            if (do_sel_q && found_n) begin
              if (!cbusy_q || best_n != cur_q) begin
                qu_q <= 8'd0;
              end
              cur_q <= best_n;
              cbusy_q <= 1'b1;
            end
          end
        end
        ST_UPD: begin
          if (running) begin
            run_v_q <= 1'b1;
            fin_q <= fin_now;
            rrpre_q <= rrpre_now;
            if (fin_now) begin
              done_v_q <= 1'b1;
            end
            if (rrpre_now) begin
              counter_q <= counter_q + 16'd1;
            end
          end
          if (last) begin
            state_q <= ST_IDLE;
            if (cbusy_q) begin
              if (fin_q || rrpre_q || fin_now || rrpre_now) begin
                qu_q <= 8'd0;
                cbusy_q <= 1'b0;
              end else begin
                qu_q <= qu_inc;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      job_id_q <= job_id_i;
      burst_q <= burst_length_i;
    end
    if (take) begin
      best_burst_q <= h_mod.burst;
      best_rem_q <= h_mod.remaining;
      best_wait_q <= h_mod.wait_cnt;
      best_age_q <= age_h;
    end
    if (state_q == ST_UPD && running) begin
      run_id_q <= head_i.job_id;
      done_id_q <= head_i.job_id;
      done_wait_q <= head_i.wait_cnt;
      done_time_q <= elapsed_q;
    end
  end

  assign result_strobe_o = strobe_q;
  assign arrival_accepted_o = acc_q;
  assign running_valid_o = run_v_q;
  assign running_id_o = run_v_q ? run_id_q : 8'd0;
  assign done_valid_o = done_v_q;
  assign done_id_o = done_v_q ? done_id_q : 8'd0;
  assign done_wait_o = done_v_q ? done_wait_q : 16'd0;
  assign done_time_o = done_v_q ? done_time_q : 32'd0;

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> state_q == ST_IDLE)
    else $error("result strobe outside idle");
  a_done_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_v_q |-> run_v_q && !acc_q)
    else $error("finished job without running job");
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> step_q == '0)
    else $error("ring not aligned in idle");
  a_pass_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEL && last) |=> state_q == ST_UPD)
    else $error("selection pass not followed by update pass");

endmodule

// ----- tb/sv/tdps_checker.sv -----
`timescale 1ns / 1ps

module tdps_checker
  import tdps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        opcode_i,
  input  logic [7:0]  job_id_i,
  input  logic [9:0]  burst_length_i,
  input  logic        result_strobe_o,
  input  logic        arrival_accepted_o,
  input  logic        running_valid_o,
  input  logic [7:0]  running_id_o,
  input  logic        done_valid_o,
  input  logic [7:0]  done_id_o,
  input  logic [15:0] done_wait_o,
  input  logic [31:0] done_time_o,
  output int          outstanding,
  output int          fail_count
);

  typedef struct packed {
    logic        accepted;
    logic        run_valid;
    logic [7:0]  run_id;
    logic        fin_valid;
    logic [7:0]  fin_id;
    logic [15:0] fin_wait;
    logic [31:0] fin_time;
  } sched_outcome_t;

  sched_outcome_t expected_results[$];

  logic [2:0]  cur_policy;
  logic [7:0]  cur_quantum;
  logic        job_live[SLOTS];
  logic [7:0]  job_tag[SLOTS];
  logic [9:0]  job_burst[SLOTS];
  logic [9:0]  job_left[SLOTS];
  logic [15:0] job_wait[SLOTS];
  logic [15:0] job_stamp[SLOTS];
  logic [15:0] stamp_next;
  int          run_slot;
  logic        run_busy;
  logic [7:0]  slice_used;
  logic [31:0] tick_count;

  function automatic logic wins_over(int a, int b, logic [2:0] pol);
    longint ra, rb;
    logic [15:0] age_a, age_b;
    age_a = stamp_next - job_stamp[a];
    age_b = stamp_next - job_stamp[b];
    if (pol == POL_HRRN) begin
      ra = (longint'(job_wait[a]) + job_burst[a]) * job_burst[b];
      rb = (longint'(job_wait[b]) + job_burst[b]) * job_burst[a];
      if (ra != rb) return ra > rb;
    end else if (pol == POL_SJF) begin
      if (job_burst[a] != job_burst[b]) return job_burst[a] < job_burst[b];
    end else if (pol == POL_SRT) begin
      if (job_left[a] != job_left[b]) return job_left[a] < job_left[b];
    end
    return age_a > age_b;
  endfunction

  function automatic sched_outcome_t schedule_request(logic op, logic [7:0] id,
                                                      logic [9:0] burst);
    sched_outcome_t r;
    logic [2:0] pol;
    logic [7:0] q;
    int best;
    logic found;
    r = '0;
    if (op == OP_ARRIVAL) begin
      if (burst == 0) return r;
      for (int s = 0; s < SLOTS; s++) begin
        if (!job_live[s]) begin
          job_live[s] = 1'b1;
          job_tag[s] = id;
          job_burst[s] = burst;
          job_left[s] = burst;
          job_wait[s] = '0;
          job_stamp[s] = stamp_next;
          stamp_next = stamp_next + 16'd1;
          r.accepted = 1'b1;
          break;
        end
      end
      return r;
    end
    tick_count = tick_count + 32'd1;
    pol = (cur_policy > POL_SRT) ? POL_FCFS : cur_policy;
    q = (cur_quantum == 0) ? 8'd1 : cur_quantum;
    if (run_busy && !job_live[run_slot]) run_busy = 1'b0;
    if (run_busy && pol == POL_RR && slice_used >= q) begin
      job_stamp[run_slot] = stamp_next;
      stamp_next = stamp_next + 16'd1;
      run_busy = 1'b0;
      slice_used = '0;
    end
    if (!run_busy || pol == POL_SRT) begin
      found = 1'b0;
      best = 0;
      for (int s = 0; s < SLOTS; s++) begin
        if (!job_live[s]) continue;
        if (!found || wins_over(s, best, pol)) begin
          best = s;
          found = 1'b1;
        end
      end
      if (found) begin
        if (!run_busy || best != run_slot) slice_used = '0;
        run_slot = best;
        run_busy = 1'b1;
      end
    end
    for (int s = 0; s < SLOTS; s++) begin
      if (job_live[s] && !(run_busy && s == run_slot) && job_wait[s] != 16'hFFFF)
        job_wait[s] = job_wait[s] + 16'd1;
    end
    if (!run_busy) return r;
    r.run_valid = 1'b1;
    r.run_id = job_tag[run_slot];
    if (job_left[run_slot] != 0) job_left[run_slot] = job_left[run_slot] - 10'd1;
    if (slice_used != 8'hFF) slice_used = slice_used + 8'd1;
    if (job_left[run_slot] == 0) begin
      r.fin_valid = 1'b1;
      r.fin_id = job_tag[run_slot];
      r.fin_wait = job_wait[run_slot];
      r.fin_time = tick_count;
      job_live[run_slot] = 1'b0;
      run_busy = 1'b0;
      slice_used = '0;
    end else if (pol == POL_RR && slice_used >= q) begin
      job_stamp[run_slot] = stamp_next;
      stamp_next = stamp_next + 16'd1;
      run_busy = 1'b0;
      slice_used = '0;
    end
    return r;
  endfunction

  assign outstanding = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sched_outcome_t exp_r;
    sched_outcome_t next_r;
    if (!rst_ni) begin
      cur_policy = POL_FCFS;
      cur_quantum = QUANTUM_RESET;
      for (int s = 0; s < SLOTS; s++) begin
        job_live[s] = 1'b0;
        job_tag[s] = '0;
        job_burst[s] = '0;
        job_left[s] = '0;
        job_wait[s] = '0;
        job_stamp[s] = '0;
      end
      stamp_next = '0;
      run_slot = 0;
      run_busy = 1'b0;
      slice_used = '0;
      tick_count = '0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (result_strobe_o) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          exp_r = expected_results[0];
          expected_results.delete(0);
          if (arrival_accepted_o !== exp_r.accepted) begin
            $error("arrival_accepted: expected %0d, got %0d", exp_r.accepted,
                   arrival_accepted_o);
            fail_count++;
          end
          if (running_valid_o !== exp_r.run_valid) begin
            $error("running_valid: expected %0d, got %0d", exp_r.run_valid, running_valid_o);
            fail_count++;
          end
          if (running_id_o !== exp_r.run_id) begin
            $error("running_id: expected %0d, got %0d", exp_r.run_id, running_id_o);
            fail_count++;
          end
          if (done_valid_o !== exp_r.fin_valid) begin
            $error("done_valid: expected %0d, got %0d", exp_r.fin_valid, done_valid_o);
            fail_count++;
          end
          if (done_id_o !== exp_r.fin_id) begin
            $error("done_id: expected %0d, got %0d", exp_r.fin_id, done_id_o);
            fail_count++;
          end
          if (done_wait_o !== exp_r.fin_wait) begin
            $error("done_wait: expected %0d, got %0d", exp_r.fin_wait, done_wait_o);
            fail_count++;
          end
          if (done_time_o !== exp_r.fin_time) begin
            $error("done_time: expected %0d, got %0d", exp_r.fin_time, done_time_o);
            fail_count++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_POLICY) cur_policy = cfg_data_i[2:0];
        else cur_quantum = cfg_data_i;
      end
      if (start_i && !busy_o) begin
        next_r = schedule_request(opcode_i, job_id_i, burst_length_i);
        expected_results.insert(expected_results.size(), next_r);
      end
    end
  end

endmodule

// ----- tb/sv/tick_driven_process_scheduler_top_tb.sv -----
`timescale 1ns / 1ps

module tick_driven_process_scheduler_top_tb;
  import tdps_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CFG_POLICY;
  logic [7:0]  cfg_data_i = '0;
  logic        opcode_i = OP_ARRIVAL;
  logic [7:0]  job_id_i = '0;
  logic [9:0]  burst_length_i = '0;
  logic        result_strobe_o;
  logic        arrival_accepted_o;
  logic        running_valid_o;
  logic [7:0]  running_id_o;
  logic        done_valid_o;
  logic [7:0]  done_id_o;
  logic [15:0] done_wait_o;
  logic [31:0] done_time_o;
  int          outstanding;
  int          fail_count;
  int          cycles = 0;
  logic        allow_gaps = 1'b1;

  tick_driven_process_scheduler_top dut (.*);
  tdps_checker u_checker (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic issue(logic op, logic [7:0] id, logic [9:0] burst);
    @(negedge clk_i);
    start_i = 1'b1;
    opcode_i = op;
    job_id_i = id;
    burst_length_i = burst;
    while (busy_o) @(negedge clk_i);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat ($urandom_range(1, 3) - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_requests();
    @(negedge clk_i);
    start_i = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_request();
    logic [9:0] burst;
    if ($urandom_range(0, 99) < 38) begin
      case ($urandom_range(0, 19))
        0: burst = '0;
        1: burst = 10'($urandom_range(1, 1023));
        2, 3: burst = 10'($urandom_range(20, 60));
        default: burst = 10'($urandom_range(1, 10));
      endcase
      issue(OP_ARRIVAL, 8'($urandom_range(0, 255)), burst);
    end else begin
      issue(OP_TICK, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
    end
  endtask

  initial begin
    logic [7:0] q_pick;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    write_reg(CFG_POLICY, {5'd0, POL_FCFS});
    write_reg(CFG_QUANTUM, QUANTUM_RESET);

    issue(OP_ARRIVAL, 8'd7, 10'd0);
    issue(OP_TICK, 8'd0, 10'd0);
    issue(OP_ARRIVAL, 8'd0, 10'd1);
    issue(OP_ARRIVAL, 8'd255, 10'd1023);
    issue(OP_ARRIVAL, 8'hAA, 10'd512);
    for (int i = 0; i < 14; i++) issue(OP_ARRIVAL, 8'(i + 16), 10'(i % 4 + 1));
    issue(OP_TICK, 8'hFF, 10'h3FF);
    issue(OP_TICK, 8'h55, 10'h155);
    issue(OP_TICK, 8'h00, 10'h000);
    issue(OP_TICK, 8'h00, 10'h000);
    drain_requests();

    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: q_pick = 8'd1;
        1: q_pick = 8'd255;
        2: q_pick = 8'd0;
        default: q_pick = 8'($urandom_range(2, 8));
      endcase
      write_reg(CFG_POLICY, phase < 8 ? 8'(phase) : 8'($urandom_range(0, 7)));
      write_reg(CFG_QUANTUM, q_pick);
      allow_gaps = (phase < 10);
      for (int i = 0; i < 45; i++) random_request();
      drain_requests();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
